// ===== hw/rtl/bfp_pkg.sv =====
// Shared types and constants of the battery frame parser.
`default_nettype none

package bfp_pkg;

    localparam int unsigned FRAME_BYTES = 30;
    localparam int unsigned POS_W       = $clog2(FRAME_BYTES + 1);

    // Position values the control logic tests against
    localparam logic [POS_W-1:0] POS_FULL      = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST_BYTE = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LAST_XOR  = POS_W'(FRAME_BYTES - 2);

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MSB_FIRST  = 3'd0,
        CFG_HEADER     = 3'd1,
        CFG_TYPE       = 3'd2,
        CFG_LENGTH     = 3'd3,
        CFG_TAIL       = 3'd4
    } cfg_index_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic       msb_first;
        logic [7:0] header_value;
        logic [7:0] type_value;
        logic [7:0] length_value;
        logic [7:0] tail_value;
    } cfg_t;

    typedef struct packed {
        logic               frame_ok;
        logic [16:0]        voltage_mv;
        logic signed [19:0] current_ma;
        logic [9:0]         charge_tenths;
        logic [6:0]         health_percent;
        logic [1:0]         charge_mode;
        logic signed [11:0] switch_temp_tenths;
        logic signed [11:0] ambient_temp_tenths;
        logic [31:0]        warning_word;
        logic [31:0]        protection_word;
        logic [7:0]         link_status;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfp_cell.sv =====
// One byte cell of the frame shift chain.
`default_nettype none

module bfp_cell (
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire logic [7:0] byte_in,
    output logic      [7:0] byte_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbor's byte on a shift, hold otherwise
    always_comb begin
        byte_next = shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bfp_decode.sv =====
// Field decode and range checks over a complete stored frame.
`default_nettype none

module bfp_decode (
    input  wire bfp_pkg::frame_t  frame,
    input  wire bfp_pkg::cfg_t    cfg,
    input  wire logic             pre_ok,
    output bfp_pkg::result_t      result
);

    function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic be);
        return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic be);
        return be ? {b0, b1} : {b1, b0};
    endfunction

    logic [31:0]        volt;
    logic signed [31:0] cur;
    logic [15:0]        soc;
    logic signed [15:0] t_sw;
    logic signed [15:0] t_amb;
    logic [31:0]        warn;
    logic [31:0]        prot;
    logic               hdr_ok;
    logic               rng_ok;
    logic               ok;

    always_comb begin
        volt  = get32(frame[3], frame[4], frame[5], frame[6], cfg.msb_first);
        cur   = $signed(get32(frame[7], frame[8], frame[9], frame[10], cfg.msb_first));
        soc   = get16(frame[11], frame[12], cfg.msb_first);
        t_sw  = $signed(get16(frame[15], frame[16], cfg.msb_first));
        t_amb = $signed(get16(frame[17], frame[18], cfg.msb_first));
        warn  = {get16(frame[19], frame[20], cfg.msb_first),
                 get16(frame[21], frame[22], cfg.msb_first)};
        prot  = {get16(frame[23], frame[24], cfg.msb_first),
                 get16(frame[25], frame[26], cfg.msb_first)};

        hdr_ok = (frame[0] == cfg.header_value) && (frame[1] == cfg.type_value) &&
                 (frame[2] == cfg.length_value) && (frame[29] == cfg.tail_value) &&
                 (frame[14] <= 8'd2);

        rng_ok = (volt >= 32'd5000) && (volt <= 32'd100000) &&
                 (cur >= -32'sd500000) && (cur <= 32'sd500000) &&
                 (soc <= 16'd1000) && (frame[13] <= 8'd100) &&
                 (t_sw >= -16'sd600) && (t_sw <= 16'sd1500) &&
                 (t_amb >= -16'sd600) && (t_amb <= 16'sd1500);

        ok = pre_ok && hdr_ok && rng_ok;

        // Drop every field of a rejected frame to zero
        result = '0;
        if (ok) begin
            result.frame_ok            = 1'b1;
            result.voltage_mv          = volt[16:0];
            result.current_ma          = cur[19:0];
            result.charge_tenths       = soc[9:0];
            result.health_percent      = frame[13][6:0];
            result.charge_mode         = frame[14][1:0];
            result.switch_temp_tenths  = t_sw[11:0];
            result.ambient_temp_tenths = t_amb[11:0];
            result.warning_word        = warn;
            result.protection_word     = prot;
            result.link_status         = frame[27];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/battery_frame_parser_top.sv =====
// Top level of the battery frame parser: byte chain, control, decode and result register.
//
// Usage:
//   Input channel (s_valid/s_ready): one frame byte per transfer, with
//   s_end_of_frame high on the final byte. A good frame is exactly 30 bytes.
//   Result channel (m_valid/m_ready): one transfer per frame, carrying
//   m_frame_ok and the decoded fields (all zero when the frame is rejected).
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (0 byte order, 1 header, 2 type, 3 length, 4 tail); write only while idle.
// Throughput: one byte per cycle while s_ready is high, back to back, across frame boundaries.
// Result path: the last byte's transfer sets the pending stage (decode of
//   the 30-cell chain), which moves into the output register once that is
//   free; m_valid rises as it loads.
// The 30 byte cells form a shift chain; bytes past the 30th are dropped
// and mark the frame as overlong.
// Reset: aresetn (synchronous, active low) clears position, overlong flag,
//   running XOR, pending and output valid flags and the configuration.
// Stall: while the output register holds an untaken result and a decoded
//   frame waits behind it, s_ready drops so the chain holds that frame.
`default_nettype none

module battery_frame_parser_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_wr_en,
    input  wire logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                     cfg_data,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_data_byte,
    input  wire logic                           s_end_of_frame,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_frame_ok,
    output logic [16:0]                         m_voltage_mv,
    output logic signed [19:0]                  m_current_ma,
    output logic [9:0]                          m_charge_tenths,
    output logic [6:0]                          m_health_percent,
    output logic [1:0]                          m_charge_mode,
    output logic signed [11:0]                  m_switch_temp_tenths,
    output logic signed [11:0]                  m_ambient_temp_tenths,
    output logic [31:0]                         m_warning_word,
    output logic [31:0]                         m_protection_word,
    output logic [7:0]                          m_link_status
);

    // Configuration registers
    bfp_pkg::cfg_t cfg_reg;
    bfp_pkg::cfg_t cfg_next;

    // Frame assembly state
    logic [bfp_pkg::POS_W-1:0] pos_reg;
    logic [bfp_pkg::POS_W-1:0] pos_next;
    logic                      too_long_reg;
    logic                      too_long_next;
    logic [7:0]                xor_reg;
    logic [7:0]                xor_next;

    // Pending stage: a complete frame sits in the chain awaiting decode
    logic pend_valid_reg;
    logic pend_valid_next;
    logic pend_ok_reg;
    logic pend_ok_next;

    // Output register
    logic              m_valid_reg;
    logic              m_valid_next;
    bfp_pkg::result_t  out_reg;
    bfp_pkg::result_t  out_next;

    bfp_pkg::frame_t   chain;
    bfp_pkg::result_t  dec_result;

    logic s_xfer;
    logic shift_en;
    logic out_free;
    logic pend_move;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_ready;
    assign pend_move = pend_valid_reg && out_free;
    // Hold the chain while a decoded frame cannot move on
    assign s_ready   = !pend_valid_reg || out_free;
    assign s_xfer    = s_valid && s_ready;
    assign shift_en  = s_xfer && (pos_reg != bfp_pkg::POS_FULL);

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                bfp_pkg::CFG_MSB_FIRST:  cfg_next.msb_first    = cfg_data[0];
                bfp_pkg::CFG_HEADER:     cfg_next.header_value = cfg_data;
                bfp_pkg::CFG_TYPE:       cfg_next.type_value   = cfg_data;
                bfp_pkg::CFG_LENGTH:     cfg_next.length_value = cfg_data;
                bfp_pkg::CFG_TAIL:       cfg_next.tail_value   = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Byte chain: new bytes enter the top cell, so after a full frame
    // cell i holds frame byte i
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < bfp_pkg::FRAME_BYTES; gi++) begin : g_cell
        if (gi == bfp_pkg::FRAME_BYTES - 1) begin : g_top
            bfp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .byte_in  (s_data_byte),
                .byte_out (chain[gi])
            );
        end else begin : g_mid
            bfp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .byte_in  (chain[gi+1]),
                .byte_out (chain[gi])
            );
        end
    end

    // ------------------------------------------------------------------
    // Frame control: position, overlong flag, running XOR over bytes 0..28
    // (a good frame leaves it at zero)
    // ------------------------------------------------------------------
    always_comb begin
        pos_next        = pos_reg;
        too_long_next   = too_long_reg;
        xor_next        = xor_reg;
        pend_valid_next = pend_valid_reg && !pend_move;
        pend_ok_next    = pend_ok_reg;

        if (s_xfer) begin
            if (pos_reg != bfp_pkg::POS_FULL) begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg <= bfp_pkg::POS_LAST_XOR) begin
                    xor_next = xor_reg ^ s_data_byte;
                end
            end else begin
                too_long_next = 1'b1;
            end

            if (s_end_of_frame) begin
                // Good length means this transfer was byte 29; XOR then covers 0..28
                pend_valid_next = 1'b1;
                pend_ok_next    = !too_long_reg && (pos_reg == bfp_pkg::POS_LAST_BYTE) &&
                                  (xor_reg == 8'd0);
                pos_next        = '0;
                too_long_next   = 1'b0;
                xor_next        = 8'd0;
            end
        end
    end

    bfp_decode u_decode (
        .frame  (chain),
        .cfg    (cfg_reg),
        .pre_ok (pend_ok_reg),
        .result (dec_result)
    );

    // ------------------------------------------------------------------
    // Output register: load on a pending move, clear valid on transfer
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        if (pend_move) begin
            m_valid_next = 1'b1;
            out_next     = dec_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= '0;
            pos_reg        <= '0;
            too_long_reg   <= 1'b0;
            xor_reg        <= 8'd0;
            pend_valid_reg <= 1'b0;
            pend_ok_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            pos_reg        <= pos_next;
            too_long_reg   <= too_long_next;
            xor_reg        <= xor_next;
            pend_valid_reg <= pend_valid_next;
            pend_ok_reg    <= pend_ok_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid               = m_valid_reg;
    assign m_frame_ok            = out_reg.frame_ok;
    assign m_voltage_mv          = out_reg.voltage_mv;
    assign m_current_ma          = out_reg.current_ma;
    assign m_charge_tenths       = out_reg.charge_tenths;
    assign m_health_percent      = out_reg.health_percent;
    assign m_charge_mode         = out_reg.charge_mode;
    assign m_switch_temp_tenths  = out_reg.switch_temp_tenths;
    assign m_ambient_temp_tenths = out_reg.ambient_temp_tenths;
    assign m_warning_word        = out_reg.warning_word;
    assign m_protection_word     = out_reg.protection_word;
    assign m_link_status         = out_reg.link_status;

`ifndef SYNTHESIS
    // Input stalls only when a decoded frame is blocked behind a full output
    a_ready_only_on_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (pend_valid_reg && m_valid_reg && !m_ready))
        else $error("s_ready low without a blocked pending frame");

    // Position never passes a full frame
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= bfp_pkg::POS_FULL)
        else $error("byte position beyond frame length");

    // A final byte transfer always leaves a frame pending
    a_eof_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_frame) |=> pend_valid_reg)
        else $error("end of frame not captured");

    // A rejected frame carries zero fields
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_ok) |-> (m_voltage_mv == 17'd0 && m_current_ma == 20'sd0 &&
                                      m_warning_word == 32'd0 && m_link_status == 8'd0))
        else $error("rejected frame with nonzero fields");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the battery frame parser: frame stimulus, scoreboard and checks.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES    = bfp_pkg::FRAME_BYTES;

    // Range limits of the decoded fields, in raw milli and tenth units
    localparam int CHECK_SPAN     = FRAME_BYTES - 2;
    localparam int VOLT_MIN       = 5000;
    localparam int VOLT_MAX       = 100000;
    localparam int CUR_LIMIT      = 500000;
    localparam int CHARGE_MAX     = 1000;
    localparam int HEALTH_MAX     = 100;
    localparam int MODE_MAX       = 2;
    localparam int TEMP_MIN       = -600;
    localparam int TEMP_MAX       = 1500;

    localparam int MAX_LEN        = 80;   // longest overlong frame we send
    localparam int DRAIN_CYCLES   = 8;    // idle wait after the last result has transferred
    localparam int HOLD_CYCLES    = 300;  // receiver back-pressure stretch
    localparam int PHASE_BYTES    = 250;
    localparam int RANDOM_PHASES  = 5;

    // Kinds of frame the generator can build; each defect but FR_NOISE breaks exactly one check
    typedef enum int {
        FR_GOOD,
        FR_BAD_HEADER,
        FR_BAD_TYPE,
        FR_BAD_LENGTH,
        FR_BAD_TAIL,
        FR_BAD_CHECK,
        FR_BAD_MODE,
        FR_LOW_VOLT,
        FR_HIGH_VOLT,
        FR_BAD_CURRENT,
        FR_BAD_CHARGE,
        FR_BAD_HEALTH,
        FR_BAD_SWITCH_TEMP,
        FR_BAD_AMBIENT_TEMP,
        FR_SHORT,
        FR_LONG,
        FR_NOISE
    } frame_kind_e;

    // Frame scoreboard: tracks the parser state byte by byte and queues the
    // decoded result that each end of frame must produce.
    class frame_scoreboard;
        logic               msb_first;
        logic [7:0]         header_byte;
        logic [7:0]         type_byte;
        logic [7:0]         length_byte;
        logic [7:0]         tail_byte;
        int                 position;
        bit                 overlong;
        logic [7:0]         running_xor;
        logic [7:0]         cells [FRAME_BYTES];
        bfp_pkg::result_t   awaited [$];
        int                 errors;

        function new();
            msb_first   = 1'b0;
            header_byte = '0;
            type_byte   = '0;
            length_byte = '0;
            tail_byte   = '0;
            position    = 0;
            overlong    = 1'b0;
            running_xor = '0;
            errors      = 0;
        endfunction

        function void set_reg(bfp_pkg::cfg_index_t idx, logic [7:0] value);
            case (idx)
                bfp_pkg::CFG_MSB_FIRST: msb_first   = value[0];
                bfp_pkg::CFG_HEADER:    header_byte = value;
                bfp_pkg::CFG_TYPE:      type_byte   = value;
                bfp_pkg::CFG_LENGTH:    length_byte = value;
                bfp_pkg::CFG_TAIL:      tail_byte   = value;
                default:                ;
            endcase
        endfunction

        // Assemble a multi-byte field in the configured byte order
        function logic [31:0] gather(int first, int count);
            logic [31:0] acc;
            acc = '0;
            for (int i = 0; i < count; i++) begin
                if (msb_first)
                    acc = (acc << 8) | 32'(cells[first + i]);
                else
                    acc = acc | (32'(cells[first + i]) << (8 * i));
            end
            return acc;
        endfunction

        function void note_byte(logic [7:0] data, logic last);
            logic [31:0]      volt;
            logic [31:0]      soc;
            logic [31:0]      warn;
            logic [31:0]      prot;
            logic [15:0]      half;
            int               cur;
            int               sw;
            int               amb;
            bit               ok;
            bfp_pkg::result_t res;

            if (position < FRAME_BYTES) begin
                cells[position] = data;
                if (position < CHECK_SPAN)
                    running_xor ^= data;
                position++;
            end else begin
                overlong = 1'b1;
            end
            if (!last)
                return;

            ok = !overlong && position == FRAME_BYTES;
            if (ok)
                ok = cells[0] == header_byte && cells[1] == type_byte &&
                     cells[2] == length_byte && cells[29] == tail_byte &&
                     cells[28] == running_xor && cells[14] <= MODE_MAX;

            res = '0;
            if (ok) begin
                volt = gather(3, 4);
                cur  = $signed(gather(7, 4));
                soc  = gather(11, 2);
                half = 16'(gather(15, 2));
                sw   = $signed(half);
                half = 16'(gather(17, 2));
                amb  = $signed(half);
                warn = (gather(19, 2) << 16) | gather(21, 2);
                prot = (gather(23, 2) << 16) | gather(25, 2);
                ok = volt >= VOLT_MIN && volt <= VOLT_MAX &&
                     cur >= -CUR_LIMIT && cur <= CUR_LIMIT &&
                     soc <= CHARGE_MAX && cells[13] <= HEALTH_MAX &&
                     sw >= TEMP_MIN && sw <= TEMP_MAX &&
                     amb >= TEMP_MIN && amb <= TEMP_MAX;
                if (ok) begin
                    res.frame_ok            = 1'b1;
                    res.voltage_mv          = volt[16:0];
                    res.current_ma          = 20'(cur);
                    res.charge_tenths       = soc[9:0];
                    res.health_percent      = cells[13][6:0];
                    res.charge_mode         = cells[14][1:0];
                    res.switch_temp_tenths  = 12'(sw);
                    res.ambient_temp_tenths = 12'(amb);
                    res.warning_word        = warn;
                    res.protection_word     = prot;
                    res.link_status         = cells[27];
                end
            end
            awaited.push_back(res);
            position    = 0;
            overlong    = 1'b0;
            running_xor = '0;
        endfunction

        function void match_field(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
                errors++;
            end
        endfunction

        function void check_result(bfp_pkg::result_t got);
            bfp_pkg::result_t want;
            if (awaited.size() == 0) begin
                $error("result transfer with no frame outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            match_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
            match_field("voltage_mv", 32'(want.voltage_mv), 32'(got.voltage_mv));
            match_field("current_ma", 32'(want.current_ma), 32'(got.current_ma));
            match_field("charge_tenths", 32'(want.charge_tenths), 32'(got.charge_tenths));
            match_field("health_percent", 32'(want.health_percent),
                        32'(got.health_percent));
            match_field("charge_mode", 32'(want.charge_mode), 32'(got.charge_mode));
            match_field("switch_temp_tenths", 32'(want.switch_temp_tenths),
                        32'(got.switch_temp_tenths));
            match_field("ambient_temp_tenths", 32'(want.ambient_temp_tenths),
                        32'(got.ambient_temp_tenths));
            match_field("warning_word", want.warning_word, got.warning_word);
            match_field("protection_word", want.protection_word, got.protection_word);
            match_field("link_status", 32'(want.link_status), 32'(got.link_status));
        endfunction
    endclass

    // Clock, reset and block ports; every input starts at a known value
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    bfp_pkg::cfg_index_t    cfg_index = bfp_pkg::CFG_MSB_FIRST;
    logic [7:0]             cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte    = '0;
    logic                   s_end_of_frame = 1'b0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic                   m_frame_ok;
    logic [16:0]            m_voltage_mv;
    logic signed [19:0]     m_current_ma;
    logic [9:0]             m_charge_tenths;
    logic [6:0]             m_health_percent;
    logic [1:0]             m_charge_mode;
    logic signed [11:0]     m_switch_temp_tenths;
    logic signed [11:0]     m_ambient_temp_tenths;
    logic [31:0]            m_warning_word;
    logic [31:0]            m_protection_word;
    logic [7:0]             m_link_status;

    frame_scoreboard   board = new();
    bfp_pkg::cfg_t     cur_cfg = '0;       // generator's copy of the register settings
    logic [7:0]        frame_buf [MAX_LEN];
    int                frame_len;
    bit                calm = 1'b0;        // no idling on either side while set
    bit                hold_request = 1'b0;
    bfp_pkg::result_t  seen_result;

    battery_frame_parser_top dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_data_byte           (s_data_byte),
        .s_end_of_frame        (s_end_of_frame),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_frame_ok            (m_frame_ok),
        .m_voltage_mv          (m_voltage_mv),
        .m_current_ma          (m_current_ma),
        .m_charge_tenths       (m_charge_tenths),
        .m_health_percent      (m_health_percent),
        .m_charge_mode         (m_charge_mode),
        .m_switch_temp_tenths  (m_switch_temp_tenths),
        .m_ambient_temp_tenths (m_ambient_temp_tenths),
        .m_warning_word        (m_warning_word),
        .m_protection_word     (m_protection_word),
        .m_link_status         (m_link_status)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Write one register; the caller lowers the write enable after the last one
    task automatic write_reg(bfp_pkg::cfg_index_t idx, logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        board.set_reg(idx, value);
    endtask

    // Load every register; call only while the block is idle
    task automatic load_config(logic be, logic [7:0] hdr, logic [7:0] typ,
                               logic [7:0] len, logic [7:0] tail);
        write_reg(bfp_pkg::CFG_MSB_FIRST, {7'd0, be});
        write_reg(bfp_pkg::CFG_HEADER, hdr);
        write_reg(bfp_pkg::CFG_TYPE, typ);
        write_reg(bfp_pkg::CFG_LENGTH, len);
        write_reg(bfp_pkg::CFG_TAIL, tail);
        cfg_wr_en <= 1'b0;
        cur_cfg = '{msb_first: be, header_value: hdr, type_value: typ,
                    length_value: len, tail_value: tail};
        @(posedge aclk);
    endtask

    // Offer one byte, idling first at random; return at the edge of its transfer
    task automatic push_byte(logic [7:0] data, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= data;
        s_end_of_frame <= last;
        // Sample ready mid-cycle, where it is settled; the transfer happens at the next edge
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        board.note_byte(data, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_len; i++)
            push_byte(frame_buf[i], i == frame_len - 1);
    endtask

    // Drop valid and wait until every frame has produced its result
    task automatic settle();
        s_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Place a multi-byte field into the frame buffer in the configured byte order
    task automatic place(int first, int count, logic [31:0] value);
        int shift;
        for (int i = 0; i < count; i++) begin
            shift = cur_cfg.msb_first ? 8 * (count - 1 - i) : 8 * i;
            frame_buf[first + i] = 8'(value >> shift);
        end
    endtask

    // Build one frame into frame_buf. corner 1 takes the low extremes, or the
    // value just outside the range for a defect; corner 2 the high extremes.
    task automatic build_frame(frame_kind_e kind, int corner);
        logic [31:0] volt, cur, soc, sw, amb, warn, prot, mag;
        logic [7:0]  health, mode, link, chk;

        case (corner)
            1: begin
                volt = VOLT_MIN; cur = -CUR_LIMIT; soc = 0; health = '0; mode = '0;
                sw = TEMP_MIN; amb = TEMP_MIN; warn = '0; prot = '0; link = '0;
            end
            2: begin
                volt = VOLT_MAX; cur = CUR_LIMIT; soc = CHARGE_MAX;
                health = 8'(HEALTH_MAX); mode = 8'(MODE_MAX); sw = TEMP_MAX; amb = TEMP_MAX;
                warn = '1; prot = '1; link = '1;
            end
            default: begin
                volt   = $urandom_range(VOLT_MIN, VOLT_MAX);
                cur    = $urandom_range(0, 2 * CUR_LIMIT) - CUR_LIMIT;
                soc    = $urandom_range(0, CHARGE_MAX);
                health = 8'($urandom_range(0, HEALTH_MAX));
                mode   = 8'($urandom_range(0, MODE_MAX));
                sw     = $urandom_range(0, TEMP_MAX - TEMP_MIN) + TEMP_MIN;
                amb    = $urandom_range(0, TEMP_MAX - TEMP_MIN) + TEMP_MIN;
                warn   = $urandom;
                prot   = $urandom;
                link   = 8'($urandom_range(0, 255));
            end
        endcase

        // Push one field out of range
        case (kind)
            FR_LOW_VOLT:
                volt = (corner == 1) ? VOLT_MIN - 1 : $urandom_range(0, VOLT_MIN - 1);
            FR_HIGH_VOLT:
                volt = (corner == 1) ? VOLT_MAX + 1 : $urandom_range(VOLT_MAX + 1, 32'hFFFF_FFFF);
            FR_BAD_CURRENT: begin
                mag = (corner == 1) ? CUR_LIMIT + 1 : $urandom_range(CUR_LIMIT + 1, 32'h8000_0000);
                cur = $urandom_range(0, 1) ? 0 - mag : mag;
            end
            FR_BAD_CHARGE:
                soc = (corner == 1) ? CHARGE_MAX + 1 : $urandom_range(CHARGE_MAX + 1, 16'hFFFF);
            FR_BAD_HEALTH:
                health = 8'((corner == 1) ? HEALTH_MAX + 1 : $urandom_range(HEALTH_MAX + 1, 255));
            FR_BAD_MODE:
                mode = 8'((corner == 1) ? MODE_MAX + 1 : $urandom_range(MODE_MAX + 1, 255));
            FR_BAD_SWITCH_TEMP, FR_BAD_AMBIENT_TEMP: begin
                if ($urandom_range(0, 1))
                    mag = (corner == 1) ? TEMP_MAX + 1 : $urandom_range(TEMP_MAX + 1, 32767);
                else
                    mag = 0 - ((corner == 1) ? 1 - TEMP_MIN : $urandom_range(1 - TEMP_MIN, 32768));
                if (kind == FR_BAD_SWITCH_TEMP)
                    sw = mag;
                else
                    amb = mag;
            end
            default: ;
        endcase

        frame_buf[0] = cur_cfg.header_value;
        frame_buf[1] = cur_cfg.type_value;
        frame_buf[2] = cur_cfg.length_value;
        // Spoil a marker byte before the check byte is computed, so only that test fails
        case (kind)
            FR_BAD_HEADER: frame_buf[0] ^= 8'($urandom_range(1, 255));
            FR_BAD_TYPE:   frame_buf[1] ^= 8'($urandom_range(1, 255));
            FR_BAD_LENGTH: frame_buf[2] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
        place(3, 4, volt);
        place(7, 4, cur);
        place(11, 2, soc);
        frame_buf[13] = health;
        frame_buf[14] = mode;
        place(15, 2, sw);
        place(17, 2, amb);
        place(19, 2, warn >> 16);
        place(21, 2, warn);
        place(23, 2, prot >> 16);
        place(25, 2, prot);
        frame_buf[27] = link;
        chk = '0;
        for (int i = 0; i < CHECK_SPAN; i++)
            chk ^= frame_buf[i];
        frame_buf[28] = chk;
        frame_buf[29] = cur_cfg.tail_value;
        if (kind == FR_BAD_CHECK)
            frame_buf[28] ^= 8'($urandom_range(1, 255));
        if (kind == FR_BAD_TAIL)
            frame_buf[29] ^= 8'($urandom_range(1, 255));

        frame_len = FRAME_BYTES;
        case (kind)
            FR_SHORT:
                frame_len = (corner == 1) ? 1 :
                            (corner == 2) ? FRAME_BYTES - 1 : $urandom_range(1, FRAME_BYTES - 1);
            FR_LONG: begin
                frame_len = (corner == 1) ? FRAME_BYTES + 1 :
                            (corner == 2) ? MAX_LEN : $urandom_range(FRAME_BYTES + 1, 40);
                for (int i = FRAME_BYTES; i < frame_len; i++)
                    frame_buf[i] = 8'($urandom_range(0, 255));
            end
            FR_NOISE: begin
                frame_len = $urandom_range(1, 40);
                for (int i = 0; i < frame_len; i++)
                    frame_buf[i] = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
    endtask

    // Result monitor: sample mid-cycle; valid and ready both high means the
    // transfer happens at the coming edge.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result = {m_frame_ok, m_voltage_mv, m_current_ma, m_charge_tenths,
                           m_health_percent, m_charge_mode, m_switch_temp_tenths,
                           m_ambient_temp_tenths, m_warning_word, m_protection_word,
                           m_link_status};
            board.check_result(seen_result);
        end
    end

    // Result receiver: random stalls, and one long hold-off on request so the
    // output stage fills and the block back-pressures the byte stream.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Main sequence
    initial begin
        int          sent;
        int          r;
        frame_kind_e kind;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every frame kind at its boundary, under the reset settings
        for (int k = FR_GOOD; k <= FR_NOISE; k++) begin
            build_frame(frame_kind_e'(k), 1);
            send_frame();
        end
        build_frame(FR_GOOD, 2);
        send_frame();
        build_frame(FR_SHORT, 2);
        send_frame();
        build_frame(FR_LONG, 2);
        send_frame();
        settle();

        // Directed: the opposite register extremes, most significant byte first
        load_config(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        build_frame(FR_GOOD, 1);
        send_frame();
        build_frame(FR_GOOD, 2);
        send_frame();
        build_frame(FR_GOOD, 0);
        send_frame();
        build_frame(FR_BAD_CHECK, 1);
        send_frame();
        settle();

        // Random phases: two with no idling, the second of them with a long receiver hold-off
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_config(phase[0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            calm = (phase == 1) || (phase == 2);
            if (phase == 2)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    kind = FR_GOOD;
                else if (r < 90)
                    kind = frame_kind_e'($urandom_range(FR_BAD_HEADER, FR_LONG));
                else
                    kind = FR_NOISE;
                r = $urandom_range(0, 9);
                build_frame(kind, (r == 0) ? 1 : (r == 1) ? 2 : 0);
                send_frame();
                sent += frame_len;
            end
            settle();
        end

        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
